>>> rtl/tpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types, register indexes and saturation helpers for the trapezoidal
// position profile core.
// ----------------------------------------------------------------------------
package tpp_pkg;

    typedef enum logic [1:0] {
        PH_STOP   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } t_phase;

    localparam logic [1:0] CFG_MAX_SPEED   = 2'd0;
    localparam logic [1:0] CFG_ACCEL_RATE  = 2'd1;
    localparam logic [1:0] CFG_DECEL_RATE  = 2'd2;
    localparam logic [1:0] CFG_TICK_PERIOD = 2'd3;

    localparam logic [30:0] RST_MAX_SPEED   = 31'd65536;
    localparam logic [30:0] RST_ACCEL_RATE  = 31'd131072;
    localparam logic [30:0] RST_DECEL_RATE  = 31'd131072;
    localparam logic [23:0] RST_TICK_PERIOD = 24'd33554;

    // ticks at or below this length leave the profile untouched
    localparam logic [23:0] MIN_TICK = 24'd16;

    function automatic logic [31:0] sat_u32(input logic [63:0] x);
        sat_u32 = (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [33:0] x);
        logic [31:0] res;
        if (x > 34'sh0_7FFF_FFFF) begin
            res = 32'h7FFF_FFFF;
        end else if (x < -34'sh0_8000_0000) begin
            res = 32'h8000_0000;
        end else begin
            res = x[31:0];
        end
        sat_s32 = res;
    endfunction

endpackage

>>> rtl/trapezoidal_position_profile_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoidal_position_profile_core
// Plans trapezoidal or triangular moves and steps the commanded position per
// tick item; one result item per input item.
// ----------------------------------------------------------------------------
// A plan item runs up to six divisions on a shared radix-2 divide/root unit,
// or five when the ramps leave no room to cruise, one 32-step square root
// and three passes through a shared 32x32 multiplier. A tick item makes four
// multiplier passes, or two in cruise. A zero-distance plan, a tick while
// stopped and a tick too short to count skip this work. The input side stalls
// while an item is in work; a finished result waits in the output register,
// so the next item is taken while it is still held.
module trapezoidal_position_profile_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [31:0] i_start_position,
    input  logic [31:0] i_target_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_position,
    output logic        o_moving,
    output logic [1:0]  o_phase
);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_ITER,
        S_P_EFF, S_P_MULX, S_P_ROOT, S_P_PEAK, S_P_TDEC, S_P_PP, S_P_SACC,
        S_P_SDEC, S_P_REST, S_P_END1, S_P_END2,
        S_T_V, S_T_P, S_T_R, S_T_NV, S_T_FIN,
        S_OUT
    } t_state;

    t_state r_state, r_ret;

    // configuration
    logic [30:0] r_max_speed, r_accel_rate, r_decel_rate;
    logic [23:0] r_tick_period;

    // profile state
    logic [31:0] r_pos, r_vel, r_goal;
    logic [31:0] r_elapsed, r_accel_end, r_cruise_end, r_decel_end;
    logic [31:0] r_peak_s, r_accel_s, r_decel_s;
    tpp_pkg::t_phase r_phase;

    // scratch
    logic [31:0] r_ma, r_mb;
    logic [63:0] r_prod;
    logic [63:0] r_src, r_q;
    logic [35:0] r_rem;
    logic [31:0] r_den;
    logic        r_sqrt;
    logic [5:0]  r_cnt;
    logic [31:0] r_absd;
    logic        r_neg;
    logic [30:0] r_pk;
    logic [31:0] r_tacc, r_tdec;
    logic [63:0] r_sum;
    logic [23:0] r_dt, r_dt2;
    logic signed [33:0] r_p;

    logic        r_ovalid;
    logic [31:0] r_opos;
    logic [1:0]  r_ophase;

    logic        in_acc;
    logic [30:0] a_eff, d_eff;
    logic [32:0] delta_pos;
    logic [31:0] absd;
    logic [31:0] end_sel, rem_t;
    logic [23:0] dt;
    logic [31:0] vmag, rate_sel, rmag;
    logic [30:0] pk;
    logic [35:0] cand, sub;
    logic        ge;
    logic [63:0] sum_all;
    logic signed [33:0] term_v, term_r, nv, nv_c;
    logic [32:0] el_sum;
    logic [31:0] el_new;
    tpp_pkg::t_phase ph_new;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_position = r_opos;
    assign o_phase    = r_ophase;
    assign o_moving   = (r_ophase != tpp_pkg::PH_STOP);

    always_comb begin
        a_eff = (r_accel_rate == 31'd0) ? 31'd1 : r_accel_rate;
        d_eff = (r_decel_rate == 31'd0) ? 31'd1 : r_decel_rate;
        delta_pos = {i_target_position[31], i_target_position}
                  - {i_start_position[31], i_start_position};
        absd  = delta_pos[32] ? 32'(-delta_pos) : delta_pos[31:0];

        case (r_phase)
            tpp_pkg::PH_ACCEL:  end_sel = r_accel_end;
            tpp_pkg::PH_CRUISE: end_sel = r_cruise_end;
            default:            end_sel = r_decel_end;
        endcase
        rem_t = (end_sel > r_elapsed) ? end_sel - r_elapsed : 32'd0;
        dt    = (rem_t < {8'd0, r_tick_period}) ? rem_t[23:0] : r_tick_period;

        vmag     = r_vel[31] ? (~r_vel + 32'd1) : r_vel;
        rate_sel = (r_phase == tpp_pkg::PH_ACCEL) ? r_accel_s : r_decel_s;
        rmag     = rate_sel[31] ? (~rate_sel + 32'd1) : rate_sel;

        // peak speed from the root result
        if ({1'b0, r_max_speed} < r_q[31:0]) begin
            pk = r_max_speed;
        end else begin
            pk = r_q[30:0];
        end
        if (pk == 31'd0) begin
            pk = 31'd1;
        end

        // shared restoring step: one quotient bit or one root bit a cycle
        if (r_sqrt) begin
            cand = {r_rem[33:0], r_src[63:62]};
            sub  = {2'b00, r_q[31:0], 2'b01};
        end else begin
            cand = {r_rem[34:0], r_src[63]};
            sub  = {4'd0, r_den};
        end
        ge = (cand >= sub);

        sum_all = r_sum + r_q;

        term_v = r_vel[31] ? -$signed({2'b00, r_prod[55:24]})
                           :  $signed({2'b00, r_prod[55:24]});
        term_r = rate_sel[31] ? -$signed({2'b00, r_prod[56:25]})
                              :  $signed({2'b00, r_prod[56:25]});
        nv = $signed({{2{r_vel[31]}}, r_vel})
           + (rate_sel[31] ? -$signed({2'b00, r_prod[55:24]})
                           :  $signed({2'b00, r_prod[55:24]}));
        nv_c = nv;
        if (r_phase == tpp_pkg::PH_ACCEL) begin
            if ((!rate_sel[31] && nv > $signed({{2{r_peak_s[31]}}, r_peak_s})) ||
                (rate_sel[31] && nv < $signed({{2{r_peak_s[31]}}, r_peak_s}))) begin
                nv_c = $signed({{2{r_peak_s[31]}}, r_peak_s});
            end
        end else begin
            if ((!rate_sel[31] && nv > 34'sd0) || (rate_sel[31] && nv < 34'sd0)) begin
                nv_c = 34'sd0;
            end
        end

        // phase cascade after the tick
        el_sum = {1'b0, r_elapsed} + {9'd0, r_dt};
        el_new = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
        ph_new = r_phase;
        if (ph_new == tpp_pkg::PH_ACCEL && el_new >= r_accel_end) begin
            ph_new = (r_cruise_end > r_accel_end) ? tpp_pkg::PH_CRUISE
                                                  : tpp_pkg::PH_DECEL;
        end
        if (ph_new == tpp_pkg::PH_CRUISE && el_new >= r_cruise_end) begin
            ph_new = tpp_pkg::PH_DECEL;
        end
        if (ph_new == tpp_pkg::PH_DECEL && el_new >= r_decel_end) begin
            ph_new = tpp_pkg::PH_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ret         <= S_IDLE;
            r_max_speed   <= tpp_pkg::RST_MAX_SPEED;
            r_accel_rate  <= tpp_pkg::RST_ACCEL_RATE;
            r_decel_rate  <= tpp_pkg::RST_DECEL_RATE;
            r_tick_period <= tpp_pkg::RST_TICK_PERIOD;
            r_pos         <= '0;
            r_vel         <= '0;
            r_goal        <= '0;
            r_elapsed     <= '0;
            r_accel_end   <= '0;
            r_cruise_end  <= '0;
            r_decel_end   <= '0;
            r_peak_s      <= '0;
            r_accel_s     <= '0;
            r_decel_s     <= '0;
            r_phase       <= tpp_pkg::PH_STOP;
            r_ovalid      <= 1'b0;
            r_opos        <= '0;
            r_ophase      <= tpp_pkg::PH_STOP;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tpp_pkg::CFG_MAX_SPEED:   r_max_speed   <= i_cfg_data;
                    tpp_pkg::CFG_ACCEL_RATE:  r_accel_rate  <= i_cfg_data;
                    tpp_pkg::CFG_DECEL_RATE:  r_decel_rate  <= i_cfg_data;
                    tpp_pkg::CFG_TICK_PERIOD: r_tick_period <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            // the output state loads or holds the result register itself
            if (!i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_action) begin
                            r_pos     <= i_start_position;
                            r_goal    <= i_target_position;
                            r_elapsed <= '0;
                            r_absd    <= absd;
                            r_neg     <= delta_pos[32];
                            if (absd == 32'd0) begin
                                r_phase      <= tpp_pkg::PH_STOP;
                                r_accel_end  <= '0;
                                r_cruise_end <= '0;
                                r_decel_end  <= '0;
                                r_state      <= S_OUT;
                            end else begin
                                r_ma    <= {1'b0, a_eff};
                                r_mb    <= {1'b0, d_eff};
                                r_ret   <= S_P_EFF;
                                r_state <= S_MUL;
                            end
                        end else if (r_phase == tpp_pkg::PH_STOP ||
                                     r_tick_period <= tpp_pkg::MIN_TICK) begin
                            r_state <= S_OUT;
                        end else begin
                            r_dt    <= dt;
                            r_ma    <= {8'd0, dt};
                            r_mb    <= {8'd0, dt};
                            r_ret   <= S_T_V;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= r_ma * r_mb;
                    r_state <= r_ret;
                end
                S_ITER: begin
                    r_rem <= ge ? cand - sub : cand;
                    r_q   <= {r_q[62:0], ge};
                    r_src <= r_sqrt ? {r_src[61:0], 2'b00} : {r_src[62:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == (r_sqrt ? 6'd31 : 6'd63)) begin
                        r_state <= r_ret;
                    end
                end
                // plan: eff = a*d / (a+d)
                S_P_EFF: begin
                    r_src   <= r_prod;
                    r_den   <= {1'b0, a_eff} + {1'b0, d_eff};
                    r_sqrt  <= 1'b0;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_ret   <= S_P_MULX;
                    r_state <= S_ITER;
                end
                S_P_MULX: begin
                    r_ma    <= r_q[31:0];
                    r_mb    <= r_absd;
                    r_ret   <= S_P_ROOT;
                    r_state <= S_MUL;
                end
                S_P_ROOT: begin
                    r_src   <= {r_prod[62:0], 1'b0};
                    r_sqrt  <= 1'b1;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_ret   <= S_P_PEAK;
                    r_state <= S_ITER;
                end
                S_P_PEAK: begin
                    r_pk    <= pk;
                    r_src   <= {9'd0, pk, 24'd0};
                    r_den   <= {1'b0, a_eff};
                    r_sqrt  <= 1'b0;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_ret   <= S_P_TDEC;
                    r_state <= S_ITER;
                end
                S_P_TDEC: begin
                    r_tacc  <= tpp_pkg::sat_u32(r_q);
                    r_src   <= {9'd0, r_pk, 24'd0};
                    r_den   <= {1'b0, d_eff};
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_ret   <= S_P_PP;
                    r_state <= S_ITER;
                end
                S_P_PP: begin
                    r_tdec  <= tpp_pkg::sat_u32(r_q);
                    r_ma    <= {1'b0, r_pk};
                    r_mb    <= {1'b0, r_pk};
                    r_ret   <= S_P_SACC;
                    r_state <= S_MUL;
                end
                S_P_SACC: begin
                    r_src   <= r_prod;
                    r_den   <= {a_eff, 1'b0};
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_ret   <= S_P_SDEC;
                    r_state <= S_ITER;
                end
                S_P_SDEC: begin
                    r_sum   <= r_q;
                    r_src   <= r_prod;
                    r_den   <= {d_eff, 1'b0};
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_ret   <= S_P_REST;
                    r_state <= S_ITER;
                end
                // cruise time only when both ramps fit in the distance
                S_P_REST: begin
                    if (sum_all <= {32'd0, r_absd}) begin
                        r_src   <= {8'd0, 32'(r_absd - sum_all[31:0]), 24'd0};
                        r_den   <= {1'b0, r_pk};
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_ret   <= S_P_END1;
                        r_state <= S_ITER;
                    end else begin
                        r_q     <= '0;
                        r_state <= S_P_END1;
                    end
                end
                S_P_END1: begin
                    r_accel_end  <= r_tacc;
                    r_cruise_end <= tpp_pkg::sat_u32({32'd0, r_tacc}
                                                     + {32'd0, tpp_pkg::sat_u32(r_q)});
                    r_state      <= S_P_END2;
                end
                S_P_END2: begin
                    r_decel_end <= tpp_pkg::sat_u32({32'd0, r_cruise_end}
                                                    + {32'd0, r_tdec});
                    if (!r_neg) begin
                        r_peak_s  <= {1'b0, r_pk};
                        r_accel_s <= {1'b0, a_eff};
                        r_decel_s <= -{1'b0, d_eff};
                    end else begin
                        r_peak_s  <= -{1'b0, r_pk};
                        r_accel_s <= -{1'b0, a_eff};
                        r_decel_s <= {1'b0, d_eff};
                    end
                    r_phase <= tpp_pkg::PH_ACCEL;
                    r_state <= S_OUT;
                end
                // tick
                S_T_V: begin
                    r_dt2   <= r_prod[47:24];
                    r_ma    <= vmag;
                    r_mb    <= {8'd0, r_dt};
                    r_ret   <= S_T_P;
                    r_state <= S_MUL;
                end
                S_T_P: begin
                    r_p <= $signed({{2{r_pos[31]}}, r_pos}) + term_v;
                    if (r_phase == tpp_pkg::PH_CRUISE) begin
                        r_state <= S_T_FIN;
                    end else begin
                        r_ma    <= rmag;
                        r_mb    <= {8'd0, r_dt2};
                        r_ret   <= S_T_R;
                        r_state <= S_MUL;
                    end
                end
                S_T_R: begin
                    r_p     <= r_p + term_r;
                    r_ma    <= rmag;
                    r_mb    <= {8'd0, r_dt};
                    r_ret   <= S_T_NV;
                    r_state <= S_MUL;
                end
                S_T_NV: begin
                    r_vel   <= tpp_pkg::sat_s32(nv_c);
                    r_state <= S_T_FIN;
                end
                S_T_FIN: begin
                    r_elapsed <= el_new;
                    r_phase   <= ph_new;
                    r_pos     <= (ph_new == tpp_pkg::PH_STOP) ? r_goal
                                                              : tpp_pkg::sat_s32(r_p);
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_opos   <= (r_phase == tpp_pkg::PH_STOP) ? r_goal : r_pos;
                        r_ophase <= r_phase;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // an accepted item always starts work before its result appears
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    // while moving, time never runs past the end of braking
    a_elapsed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != tpp_pkg::PH_STOP) |-> (r_elapsed <= r_decel_end))
        else $error("elapsed time beyond end of move");

    // a stopped result reports the goal position
    a_stop_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && (!r_ovalid || !i_stall) && (r_phase == tpp_pkg::PH_STOP))
        |=> (r_opos == $past(r_goal)))
        else $error("stopped result not at goal");

    // the phase ends of a planned move are ordered
    a_end_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_accel_end <= r_cruise_end)
                                 && (r_cruise_end <= r_decel_end)))
        else $error("phase end times out of order");
`endif

endmodule

>>> dv/trapezoidal_position_profile_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoidal_position_profile_core_test
// Drives plan and tick items through the profile core under random idling
// and output back-pressure, predicts every result and checks it field by
// field.
// ----------------------------------------------------------------------------

class profile_scoreboard;
    logic [30:0] max_speed, accel_rate, decel_rate;
    logic [23:0] tick_period;
    logic signed [31:0] cur_pos, cur_vel, goal_pos, peak_vel, acc_s, dec_s;
    logic [31:0] elapsed, accel_end, cruise_end, decel_end;
    tpp_pkg::t_phase phase;
    logic [31:0] exp_pos[$];
    logic exp_moving[$];
    tpp_pkg::t_phase exp_phase[$];
    int errors;

    function void reset_state();
        max_speed = tpp_pkg::RST_MAX_SPEED;
        accel_rate = tpp_pkg::RST_ACCEL_RATE;
        decel_rate = tpp_pkg::RST_DECEL_RATE;
        tick_period = tpp_pkg::RST_TICK_PERIOD;
        cur_pos = 0; cur_vel = 0; goal_pos = 0;
        peak_vel = 0; acc_s = 0; dec_s = 0;
        elapsed = 0; accel_end = 0; cruise_end = 0; decel_end = 0;
        phase = tpp_pkg::PH_STOP;
        errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] val);
        case (idx)
            tpp_pkg::CFG_MAX_SPEED:   max_speed = val;
            tpp_pkg::CFG_ACCEL_RATE:  accel_rate = val;
            tpp_pkg::CFG_DECEL_RATE:  decel_rate = val;
            tpp_pkg::CFG_TICK_PERIOD: tick_period = val[23:0];
            default: ;
        endcase
    endfunction

    static function logic [31:0] clip_u(logic [63:0] x);
        return (x[63:32] != 0) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    static function logic signed [31:0] clip_s(longint x);
        if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (x < -64'sh8000_0000) return 32'h8000_0000;
        return x[31:0];
    endfunction

    static function logic [63:0] root(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - r - b;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // signed times unsigned, shifted, truncated toward zero
    static function longint scaled(longint v, logic [63:0] m, int s);
        logic [63:0] mag, r;
        mag = v < 0 ? -v : v;
        r = (mag * m) >> s;
        return v < 0 ? -longint'(r) : longint'(r);
    endfunction

    function void plan(logic signed [31:0] sp, logic signed [31:0] tp);
        logic [63:0] a, d, absd, eff, vf, pk, sacc, sdec;
        logic [31:0] tacc, tdec, tcr;
        longint delta;
        a = accel_rate != 0 ? accel_rate : 1;
        d = decel_rate != 0 ? decel_rate : 1;
        delta = longint'(tp) - longint'(sp);
        absd = delta < 0 ? -delta : delta;
        cur_pos = sp;
        goal_pos = tp;
        elapsed = 0;
        if (absd == 0) begin
            phase = tpp_pkg::PH_STOP;
            accel_end = 0; cruise_end = 0; decel_end = 0;
            return;
        end
        eff = (a * d) / (a + d);
        vf = root(2 * eff * absd);
        pk = max_speed < vf ? max_speed : vf;
        if (pk == 0) pk = 1;
        tacc = clip_u((pk << 24) / a);
        tdec = clip_u((pk << 24) / d);
        sacc = (pk * pk) / (2 * a);
        sdec = (pk * pk) / (2 * d);
        tcr = 0;
        if (sacc + sdec <= absd) tcr = clip_u(((absd - sacc - sdec) << 24) / pk);
        accel_end = tacc;
        cruise_end = clip_u(64'(tacc) + tcr);
        decel_end = clip_u(64'(cruise_end) + tdec);
        if (delta > 0) begin
            peak_vel = pk[31:0]; acc_s = a[31:0]; dec_s = -d[31:0];
        end else begin
            peak_vel = -pk[31:0]; acc_s = -a[31:0]; dec_s = d[31:0];
        end
        phase = tpp_pkg::PH_ACCEL;
    endfunction

    function void tick();
        logic [31:0] phase_end, rem, dt;
        logic [63:0] dt2;
        longint v, p, r, nv;
        if (phase == tpp_pkg::PH_STOP || tick_period <= tpp_pkg::MIN_TICK) return;
        phase_end = phase == tpp_pkg::PH_ACCEL ? accel_end :
                    phase == tpp_pkg::PH_CRUISE ? cruise_end : decel_end;
        rem = phase_end > elapsed ? phase_end - elapsed : 0;
        dt = rem < tick_period ? rem : tick_period;
        dt2 = (64'(dt) * dt) >> 24;
        v = cur_vel;
        p = longint'(cur_pos) + scaled(v, dt, 24);
        if (phase != tpp_pkg::PH_CRUISE) begin
            r = phase == tpp_pkg::PH_ACCEL ? acc_s : dec_s;
            p = p + scaled(r, dt2, 25);
            nv = v + scaled(r, dt, 24);
            if (phase == tpp_pkg::PH_ACCEL) begin
                if ((r > 0 && nv > peak_vel) || (r < 0 && nv < peak_vel)) nv = peak_vel;
            end else begin
                if ((r > 0 && nv > 0) || (r < 0 && nv < 0)) nv = 0;
            end
            cur_vel = clip_s(nv);
        end
        cur_pos = clip_s(p);
        elapsed = clip_u(64'(elapsed) + dt);
        if (phase == tpp_pkg::PH_ACCEL && elapsed >= accel_end)
            phase = cruise_end > accel_end ? tpp_pkg::PH_CRUISE : tpp_pkg::PH_DECEL;
        if (phase == tpp_pkg::PH_CRUISE && elapsed >= cruise_end) phase = tpp_pkg::PH_DECEL;
        if (phase == tpp_pkg::PH_DECEL && elapsed >= decel_end) begin
            phase = tpp_pkg::PH_STOP;
            cur_pos = goal_pos;
        end
    endfunction

    function void note_item(logic act, logic [31:0] sp, logic [31:0] tp);
        if (act == 1'b0) plan(sp, tp);
        else tick();
        exp_pos.push_back(phase == tpp_pkg::PH_STOP ? goal_pos : cur_pos);
        exp_moving.push_back(phase != tpp_pkg::PH_STOP);
        exp_phase.push_back(phase);
    endfunction

    function void check_result(logic [31:0] pos, logic mov, logic [1:0] ph);
        logic [31:0] e_pos;
        if (exp_pos.size() == 0) begin
            $display("%0t: unexpected result pos=%h moving=%b phase=%0d", $time, pos, mov, ph);
            errors++;
            return;
        end
        e_pos = exp_pos.pop_front();
        if (e_pos !== pos) begin
            $display("%0t: position expected %h actual %h", $time, e_pos, pos);
            errors++;
        end
        if (exp_moving[0] !== mov) begin
            $display("%0t: moving expected %b actual %b", $time, exp_moving[0], mov);
            errors++;
        end
        if (exp_phase[0] !== tpp_pkg::t_phase'(ph)) begin
            $display("%0t: phase expected %0d actual %0d", $time, exp_phase[0], ph);
            errors++;
        end
        void'(exp_moving.pop_front());
        void'(exp_phase.pop_front());
    endfunction

    function int pending();
        return exp_pos.size();
    endfunction
endclass

module trapezoidal_position_profile_core_test;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [30:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [31:0] i_start_position;
    logic [31:0] i_target_position;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_position;
    logic        o_moving;
    logic [1:0]  o_phase;

    profile_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;

    trapezoidal_position_profile_core i_dut (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // one write, then the enable is dropped again
    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    // valid stays up after the item is taken; the next call or drain decides it
    task automatic send_item(logic act, logic [31:0] sp, logic [31:0] tp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_start_position <= sp;
        i_target_position <= tp;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_item(act, sp, tp);
        @(negedge i_clk);
    endtask

    // waits out every expected result, then the block's own tail
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(65535, 0) << $urandom_range(12, 0);
            2: return -($urandom_range(65535, 0) << $urandom_range(12, 0));
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom_range(20) << 16;
        endcase
    endfunction

    // a move plus ticks with random content, sometimes cut short by a replan
    task automatic random_move(int ticks);
        logic [31:0] sp, tp;
        sp = rand_pos();
        tp = $urandom_range(9) == 0 ? sp : sp + rand_pos();
        if ($urandom_range(19) == 0) tp = $urandom;
        send_item(1'b0, sp, tp);
        for (int k = 0; k < ticks; k++) send_item(1'b1, $urandom, $urandom);
    endtask

    task automatic config_set(int sel);
        case (sel)
            0: begin
                write_reg(tpp_pkg::CFG_MAX_SPEED, 31'h7FFF_FFFF);
                write_reg(tpp_pkg::CFG_ACCEL_RATE, 31'h7FFF_FFFF);
                write_reg(tpp_pkg::CFG_DECEL_RATE, 31'h7FFF_FFFF);
                write_reg(tpp_pkg::CFG_TICK_PERIOD, 31'h00FF_FFFF);
            end
            1: begin
                write_reg(tpp_pkg::CFG_MAX_SPEED, 31'd1);
                write_reg(tpp_pkg::CFG_ACCEL_RATE, 31'd1);
                write_reg(tpp_pkg::CFG_DECEL_RATE, 31'd1);
                write_reg(tpp_pkg::CFG_TICK_PERIOD, 31'd17);
            end
            2: begin
                write_reg(tpp_pkg::CFG_MAX_SPEED, 31'($urandom_range(32'h0100_0000, 1)));
                write_reg(tpp_pkg::CFG_ACCEL_RATE, 31'($urandom_range(32'h0200_0000, 1)));
                write_reg(tpp_pkg::CFG_DECEL_RATE, 31'($urandom_range(32'h0200_0000, 1)));
                write_reg(tpp_pkg::CFG_TICK_PERIOD, 31'($urandom_range(32'h0040_0000, 17)));
            end
            default: begin
                write_reg(tpp_pkg::CFG_MAX_SPEED, 31'(32'd10 << 16));
                write_reg(tpp_pkg::CFG_ACCEL_RATE, 31'(32'd40 << 16));
                write_reg(tpp_pkg::CFG_DECEL_RATE, 31'(32'd80 << 16));
                write_reg(tpp_pkg::CFG_TICK_PERIOD, 31'd167772);
            end
        endcase
    endtask

    // result side: random stall, one long hold-off, checking
    initial begin
        i_stall = 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (600) @(negedge i_clk);
                hold_off = 1'b0;
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_position, o_moving, o_phase);
    end

    initial begin
        #150ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        sb = new();
        sb.reset_state();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = tpp_pkg::CFG_MAX_SPEED;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_action = 1'b0;
        i_start_position = '0;
        i_target_position = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset settings, stopped tick, zero distance, extremes
        send_item(1'b1, 32'h0, 32'h0);
        send_item(1'b0, 32'h0001_0000, 32'h0001_0000);
        send_item(1'b0, 32'h0, 32'h0003_0000);
        repeat (6) send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(1'b1, 32'h0, 32'h0);
        send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(1'b1, 32'h0, 32'h0);
        drain();
        config_set(0);
        send_item(1'b0, 32'h0, 32'h0000_0001);
        repeat (3) send_item(1'b1, 32'h0, 32'h0);
        send_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        repeat (3) send_item(1'b1, 32'h0, 32'h0);
        drain();
        // short tick leaves a moving profile untouched
        write_reg(tpp_pkg::CFG_TICK_PERIOD, 31'd16);
        send_item(1'b0, 32'h0, 32'h0010_0000);
        repeat (2) send_item(1'b1, 32'h0, 32'h0);
        drain();
        config_set(1);
        send_item(1'b0, 32'h0, 32'h0000_0001);
        repeat (2) send_item(1'b1, 32'h0, 32'h0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = ph == 0 ? 8 : ph == 1 ? 70 : 0;
            recv_idle_pct = ph == 0 ? 70 : ph == 1 ? 8 : 0;
            for (int c = 0; c < 4; c++) begin
                drain();
                config_set(c == 0 ? 3 : c == 3 && ph == 2 ? 0 : 2);
                if (ph == 0 && c == 1) hold_off = 1'b1;
                for (int m = 0; m < 10; m++) random_move($urandom_range(24, 0));
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
